// File: hw/rtl/lko_pkg.sv
// ----------------------------------------------------------------------------
// lko_pkg
// Shared constants, codes and stage types of the keyed logo overlay.
// ----------------------------------------------------------------------------
package lko_pkg;

  // Store geometry
  localparam int LOGO_MAX_WIDTH  = 512;
  localparam int LOGO_MAX_HEIGHT = 512;
  localparam int FRAME_MAX_DIM   = 4096;
  localparam int CHROMA_W        = (LOGO_MAX_WIDTH + 1) / 2;
  localparam int CHROMA_H        = (LOGO_MAX_HEIGHT + 1) / 2;

  localparam int LX_W    = $clog2(LOGO_MAX_WIDTH);
  localparam int LY_W    = $clog2(LOGO_MAX_HEIGHT);
  localparam int CX_W    = LX_W - 1;
  localparam int CY_W    = LY_W - 1;
  // one luma bank per (x, y) parity, same shape as a chroma store
  localparam int BANK_AW = CX_W + CY_W;

  // Field widths
  localparam int VAL_W  = 8;
  localparam int CRD_W  = 12;
  localparam int SDIM_W = 13;
  localparam int LDIM_W = 10;
  // signed position: 2*col (13 bits) minus an offset, plus sign and headroom
  localparam int POS_W  = 15;

  // Codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PROC = 1'b1;

  localparam logic [1:0] PLANE_Y  = 2'd0;
  localparam logic [1:0] PLANE_CB = 2'd1;
  localparam logic [1:0] PLANE_CR = 2'd2;

  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LOGO_WIDTH    = 3'd2;
  localparam logic [2:0] REG_LOGO_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_KEY_LUMA      = 3'd4;

  localparam logic [LDIM_W-1:0] LOGO_DIM_RESET = LDIM_W'(360);

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic             valid;
    logic             func;
    logic [1:0]       plane;
    logic [VAL_W-1:0] value;
  } item_t;

  // after geometry: four candidate logo positions and load target
  typedef struct packed {
    item_t                 it;
    logic [3:0]            hit;
    logic [3:0][LX_W-1:0]  lx;
    logic [3:0][LY_W-1:0]  ly;
    logic                  xpar;
    logic                  ypar;
    logic                  ld_luma;
    logic                  ld_chroma;
    logic [LX_W-1:0]       ld_col;
    logic [LY_W-1:0]       ld_row;
  } geom_t;

  // after key test
  typedef struct packed {
    item_t            it;
    logic             rep;
    logic [VAL_W-1:0] luma;
  } mix_t;

endpackage

// File: hw/rtl/yuv420_keyed_logo_overlay.sv
// ----------------------------------------------------------------------------
// yuv420_keyed_logo_overlay
// Luma-keyed overlay of a planar 4:2:0 logo, centred on a sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Configure the five registers on the cfg channel, then load the logo
//   with load words (tuser func = 0), one sample per word, into the luma,
//   Cb and Cr stores. Process words (func = 1) carry one source sample and
//   return one output word: the logo sample where the logo is opaque, else
//   the source sample, with tuser flagging a replacement. Load words return
//   nothing. Every logo entry a process word can reach must be loaded first;
//   the stores have no reset contents and no clearing pass.
// Timing:
//   One word per cycle sustained on both sides unless stalled. An accepted
//   word passes two geometry stages, the luma bank read, the key test with
//   chroma store read, and the output register. The four luma candidates
//   of a chroma word are read at once from four parity banks.
// Reset:
//   Clears all pipeline valid bits and sets the registers to their reset
//   values (logo 360 x 360, source 0 x 0, key 0).
// Stall:
//   With m_axis_tready low, words in flight close up any bubbles; input is
//   held off only once all five stages are full.
// ----------------------------------------------------------------------------
module yuv420_keyed_logo_overlay (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // col[11:0], row[23:12], sample_value[31:24]
  input  logic [2:0]                     s_axis_tuser,  // func[0], plane[2:1]
  // output words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // out_value[7:0]
  output logic [0:0]                     m_axis_tuser,  // replaced[0]
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [lko_pkg::SDIM_W-1:0]     cfg_data
);

  // configuration registers
  logic [lko_pkg::SDIM_W-1:0] source_width;
  logic [lko_pkg::SDIM_W-1:0] source_height;
  logic [lko_pkg::LDIM_W-1:0] logo_width;
  logic [lko_pkg::LDIM_W-1:0] logo_height;
  logic [lko_pkg::VAL_W-1:0]  key_luma;

  // clamped dims and centring offsets
  logic [lko_pkg::SDIM_W-1:0] sw_c;
  logic [lko_pkg::SDIM_W-1:0] sh_c;
  logic [lko_pkg::LDIM_W-1:0] lw_c;
  logic [lko_pkg::LDIM_W-1:0] lh_c;
  lko_pkg::pos_t              d_x;
  lko_pkg::pos_t              d_y;
  lko_pkg::pos_t              off_x;
  lko_pkg::pos_t              off_y;

  // pipeline
  lko_pkg::item_t             in_item;
  lko_pkg::geom_t             s2;
  lko_pkg::mix_t              s4;
  logic [lko_pkg::VAL_W-1:0]  cb_q;
  logic [lko_pkg::VAL_W-1:0]  cr_q;
  logic                       v1;
  logic                       v3;
  logic                       en1;
  logic                       en2;
  logic                       en3;
  logic                       en4;
  logic                       en5;
  logic [lko_pkg::VAL_W-1:0]  out_next;

  // --------------------------------------------------------------------------
  // Register file; writes are always taken
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= '0;
      source_height <= '0;
      logo_width    <= lko_pkg::LOGO_DIM_RESET;
      logo_height   <= lko_pkg::LOGO_DIM_RESET;
      key_luma      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lko_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        lko_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        lko_pkg::REG_LOGO_WIDTH:    logo_width    <= cfg_data[lko_pkg::LDIM_W-1:0];
        lko_pkg::REG_LOGO_HEIGHT:   logo_height   <= cfg_data[lko_pkg::LDIM_W-1:0];
        lko_pkg::REG_KEY_LUMA:      key_luma      <= cfg_data[lko_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to store and frame limits; offset = (source - logo) / 2 rounded
  // toward zero, so a logo larger than the source gets a negative offset.
  assign sw_c = (source_width > lko_pkg::SDIM_W'(lko_pkg::FRAME_MAX_DIM))
              ? lko_pkg::SDIM_W'(lko_pkg::FRAME_MAX_DIM) : source_width;
  assign sh_c = (source_height > lko_pkg::SDIM_W'(lko_pkg::FRAME_MAX_DIM))
              ? lko_pkg::SDIM_W'(lko_pkg::FRAME_MAX_DIM) : source_height;
  assign lw_c = (logo_width > lko_pkg::LDIM_W'(lko_pkg::LOGO_MAX_WIDTH))
              ? lko_pkg::LDIM_W'(lko_pkg::LOGO_MAX_WIDTH) : logo_width;
  assign lh_c = (logo_height > lko_pkg::LDIM_W'(lko_pkg::LOGO_MAX_HEIGHT))
              ? lko_pkg::LDIM_W'(lko_pkg::LOGO_MAX_HEIGHT) : logo_height;

  assign d_x   = lko_pkg::pos_t'(sw_c) - lko_pkg::pos_t'(lw_c);
  assign d_y   = lko_pkg::pos_t'(sh_c) - lko_pkg::pos_t'(lh_c);
  assign off_x = (d_x + lko_pkg::pos_t'(d_x[lko_pkg::POS_W-1])) >>> 1;
  assign off_y = (d_y + lko_pkg::pos_t'(d_y[lko_pkg::POS_W-1])) >>> 1;

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor moves
  // --------------------------------------------------------------------------
  assign en5 = !m_axis_tvalid || m_axis_tready;
  assign en4 = !s4.it.valid || en5;
  assign en3 = !v3 || en4;
  assign en2 = !s2.it.valid || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  assign in_item.valid = s_axis_tvalid;
  assign in_item.func  = s_axis_tuser[0];
  assign in_item.plane = s_axis_tuser[2:1];
  assign in_item.value = s_axis_tdata[31:24];

  lko_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .col     (s_axis_tdata[11:0]),
    .row     (s_axis_tdata[23:12]),
    .off_x   (off_x),
    .off_y   (off_y),
    .logo_w  (lw_c),
    .logo_h  (lh_c),
    .en1     (en1),
    .en2     (en2),
    .v1      (v1),
    .s2      (s2)
  );

  lko_lookup u_lookup (
    .clk  (clk),
    .rst  (rst),
    .s2   (s2),
    .en3  (en3),
    .en4  (en4),
    .key  (key_luma),
    .v3   (v3),
    .s4   (s4),
    .cb_q (cb_q),
    .cr_q (cr_q)
  );

  // --------------------------------------------------------------------------
  // Output register; load words drop out here
  // --------------------------------------------------------------------------
  always_comb begin
    out_next = s4.it.value;
    if (s4.rep) begin
      unique case (s4.it.plane)
        lko_pkg::PLANE_Y:  out_next = s4.luma;
        lko_pkg::PLANE_CB: out_next = cb_q;
        lko_pkg::PLANE_CR: out_next = cr_q;
        default:           out_next = s4.it.value;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en5) begin
      m_axis_tvalid <= s4.it.valid && (s4.it.func == lko_pkg::FUNC_PROC);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      m_axis_tdata    <= out_next;
      m_axis_tuser[0] <= s4.rep;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // input is held off only when the whole pipe is backed up behind a stall
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  // a luma replacement must come from an opaque logo pixel
  a_luma_opaque: assert property (@(posedge clk) disable iff (rst)
    (s4.it.valid && s4.rep && (s4.it.plane == lko_pkg::PLANE_Y))
      |-> ((s4.luma != '0) && (s4.luma != key_luma)))
    else $error("luma replaced by a transparent logo pixel");

  // load words never flag a replacement
  a_load_no_rep: assert property (@(posedge clk) disable iff (rst)
    (s4.it.valid && (s4.it.func == lko_pkg::FUNC_LOAD)) |-> !s4.rep)
    else $error("load word marked as replacement");

  // output valid rises only behind a process word in stage 4
  a_out_from_proc: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s4.it.valid && (s4.it.func == lko_pkg::FUNC_PROC)))
    else $error("output word without a process word behind it");

endmodule

// File: hw/rtl/lko_ram.sv
// ----------------------------------------------------------------------------
// lko_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lko_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/lko_geom.sv
// ----------------------------------------------------------------------------
// lko_geom
// Stages 1-2: source position to logo position, bounds test, load decode.
// ----------------------------------------------------------------------------
module lko_geom (
  input  logic                              clk,
  input  logic                              rst,
  input  lko_pkg::item_t                    in_item,
  input  logic [lko_pkg::CRD_W-1:0]         col,
  input  logic [lko_pkg::CRD_W-1:0]         row,
  input  lko_pkg::pos_t                     off_x,
  input  lko_pkg::pos_t                     off_y,
  input  logic [lko_pkg::LDIM_W-1:0]        logo_w,
  input  logic [lko_pkg::LDIM_W-1:0]        logo_h,
  input  logic                              en1,
  input  logic                              en2,
  output logic                              v1,
  output lko_pkg::geom_t                    s2
);

  lko_pkg::item_t              it1;
  lko_pkg::pos_t               x0;
  lko_pkg::pos_t               y0;
  logic [lko_pkg::CRD_W-1:0]   col1;
  logic [lko_pkg::CRD_W-1:0]   row1;
  lko_pkg::pos_t               x0_in;
  lko_pkg::pos_t               y0_in;
  lko_pkg::pos_t               xk [4];
  lko_pkg::pos_t               yk [4];
  lko_pkg::geom_t              s2_next;

  // luma uses (col,row); chroma covers luma (2col,2row) .. (2col+1,2row+1)
  always_comb begin
    if (in_item.plane == lko_pkg::PLANE_Y) begin
      x0_in = lko_pkg::pos_t'(col) - off_x;
      y0_in = lko_pkg::pos_t'(row) - off_y;
    end else begin
      x0_in = lko_pkg::pos_t'({col, 1'b0}) - off_x;
      y0_in = lko_pkg::pos_t'({row, 1'b0}) - off_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      it1  <= in_item;
      x0   <= x0_in;
      y0   <= y0_in;
      col1 <= col;
      row1 <= row;
    end
  end

  always_comb begin
    logic use_k;
    s2_next          = '0;
    s2_next.it       = it1;
    s2_next.it.valid = v1;
    s2_next.xpar     = x0[0];
    s2_next.ypar     = y0[0];
    for (int k = 0; k < 4; k++) begin
      xk[k] = x0 + lko_pkg::pos_t'(k & 1);
      yk[k] = y0 + lko_pkg::pos_t'(k >> 1);
      if (it1.plane == lko_pkg::PLANE_Y) begin
        use_k = (k == 0);
      end else begin
        use_k = (it1.plane == lko_pkg::PLANE_CB) || (it1.plane == lko_pkg::PLANE_CR);
      end
      s2_next.hit[k] = (it1.func == lko_pkg::FUNC_PROC) && use_k
                     && !xk[k][lko_pkg::POS_W-1] && (xk[k] < lko_pkg::pos_t'(logo_w))
                     && !yk[k][lko_pkg::POS_W-1] && (yk[k] < lko_pkg::pos_t'(logo_h));
      s2_next.lx[k] = xk[k][lko_pkg::LX_W-1:0];
      s2_next.ly[k] = yk[k][lko_pkg::LY_W-1:0];
    end
    s2_next.ld_luma   = (it1.func == lko_pkg::FUNC_LOAD) && (it1.plane == lko_pkg::PLANE_Y)
                      && (col1 < lko_pkg::CRD_W'(lko_pkg::LOGO_MAX_WIDTH))
                      && (row1 < lko_pkg::CRD_W'(lko_pkg::LOGO_MAX_HEIGHT));
    s2_next.ld_chroma = (it1.func == lko_pkg::FUNC_LOAD)
                      && ((it1.plane == lko_pkg::PLANE_CB) || (it1.plane == lko_pkg::PLANE_CR))
                      && (col1 < lko_pkg::CRD_W'(lko_pkg::CHROMA_W))
                      && (row1 < lko_pkg::CRD_W'(lko_pkg::CHROMA_H));
    s2_next.ld_col    = col1[lko_pkg::LX_W-1:0];
    s2_next.ld_row    = row1[lko_pkg::LY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.it.valid <= 1'b0;
    end else if (en2) begin
      s2.it.valid <= s2_next.it.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2.it.func  <= s2_next.it.func;
      s2.it.plane <= s2_next.it.plane;
      s2.it.value <= s2_next.it.value;
      s2.hit       <= s2_next.hit;
      s2.lx        <= s2_next.lx;
      s2.ly        <= s2_next.ly;
      s2.xpar      <= s2_next.xpar;
      s2.ypar      <= s2_next.ypar;
      s2.ld_luma   <= s2_next.ld_luma;
      s2.ld_chroma <= s2_next.ld_chroma;
      s2.ld_col    <= s2_next.ld_col;
      s2.ld_row    <= s2_next.ld_row;
    end
  end

endmodule

// File: hw/rtl/lko_lookup.sv
// ----------------------------------------------------------------------------
// lko_lookup
// Stages 3-4: four parallel luma bank reads, key test, chroma store read.
// ----------------------------------------------------------------------------
module lko_lookup (
  input  logic                          clk,
  input  logic                          rst,
  input  lko_pkg::geom_t                s2,
  input  logic                          en3,
  input  logic                          en4,
  input  logic [lko_pkg::VAL_W-1:0]     key,
  output logic                          v3,
  output lko_pkg::mix_t                 s4,
  output logic [lko_pkg::VAL_W-1:0]     cb_q,
  output logic [lko_pkg::VAL_W-1:0]     cr_q
);

  lko_pkg::geom_t                  g3;
  logic [lko_pkg::VAL_W-1:0]       lum_q [4];
  logic [lko_pkg::VAL_W-1:0]       lum   [4];
  logic [3:0]                      opq;
  logic [1:0]                      sel;
  logic                            rep;
  logic [lko_pkg::BANK_AW-1:0]     c_raddr;
  logic [lko_pkg::BANK_AW-1:0]     c_waddr;
  logic                            cb_we;
  logic                            cr_we;

  // Bank {py,px} holds logo pixels whose (y,x) parity is (py,px); the four
  // candidates of a chroma word always fall in four different banks.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]                  kb;
    logic                        we;
    logic [lko_pkg::BANK_AW-1:0] raddr;

    assign kb    = 2'(b) ^ {s2.ypar, s2.xpar};
    assign raddr = {s2.ly[kb][lko_pkg::LY_W-1:1], s2.lx[kb][lko_pkg::LX_W-1:1]};
    assign we    = en3 && s2.it.valid && s2.ld_luma
                && ({s2.ld_row[0], s2.ld_col[0]} == 2'(b));

    lko_ram #(
      .AW (lko_pkg::BANK_AW),
      .DW (lko_pkg::VAL_W)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr ({s2.ld_row[lko_pkg::LY_W-1:1], s2.ld_col[lko_pkg::LX_W-1:1]}),
      .wdata (s2.it.value),
      .re    (en3),
      .raddr (raddr),
      .rdata (lum_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= s2.it.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      g3 <= s2;
    end
  end

  // last opaque candidate in raster order wins
  always_comb begin
    sel = 2'd0;
    rep = 1'b0;
    for (int k = 0; k < 4; k++) begin
      lum[k] = lum_q[{g3.ly[k][0], g3.lx[k][0]}];
      opq[k] = g3.hit[k] && (lum[k] != '0) && (lum[k] != key);
      if (opq[k]) begin
        sel = 2'(k);
        rep = 1'b1;
      end
    end
  end

  assign c_raddr = {g3.ly[sel][lko_pkg::LY_W-1:1], g3.lx[sel][lko_pkg::LX_W-1:1]};
  assign c_waddr = {g3.ld_row[lko_pkg::CY_W-1:0], g3.ld_col[lko_pkg::CX_W-1:0]};
  assign cb_we   = en4 && v3 && g3.ld_chroma && (g3.it.plane == lko_pkg::PLANE_CB);
  assign cr_we   = en4 && v3 && g3.ld_chroma && (g3.it.plane == lko_pkg::PLANE_CR);

  lko_ram #(
    .AW (lko_pkg::BANK_AW),
    .DW (lko_pkg::VAL_W)
  ) u_cb (
    .clk   (clk),
    .we    (cb_we),
    .waddr (c_waddr),
    .wdata (g3.it.value),
    .re    (en4),
    .raddr (c_raddr),
    .rdata (cb_q)
  );

  lko_ram #(
    .AW (lko_pkg::BANK_AW),
    .DW (lko_pkg::VAL_W)
  ) u_cr (
    .clk   (clk),
    .we    (cr_we),
    .waddr (c_waddr),
    .wdata (g3.it.value),
    .re    (en4),
    .raddr (c_raddr),
    .rdata (cr_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.it.valid <= 1'b0;
    end else if (en4) begin
      s4.it.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4.it.func  <= g3.it.func;
      s4.it.plane <= g3.it.plane;
      s4.it.value <= g3.it.value;
      s4.rep      <= rep;
      s4.luma     <= lum[sel];
    end
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed 4:2:0 logo overlay.
// A short table of directed words runs first. Most of its outputs are typed
// in, the rest are predicted. Fixed and then random phases follow, each with
// its own frame and logo geometry and key. A phase loads a patch of the logo,
// then sends process words aimed at that patch, mixed with stray loads and
// noise. Every output word is checked, the predicted ones against an in-bench
// model of the overlay. The model also tracks which store entries have been
// written, so that no process word ever reads an entry that was never loaded.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lko_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int PIPE_LATENCY  = 5;         // accept to output valid
  localparam int RX_HOLD_WORDS = 64;        // long receiver hold-off, in cycles
  localparam int MAX_REPORTS   = 10;
  localparam int RUN_LIMIT_NS  = 10_000_000;

  localparam logic [1:0] PLANE_NONE = 2'd3;  // no such plane: load ignored, process passes

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // one input word, as the fields of the work item
  typedef struct packed {
    logic             func;
    logic [1:0]       plane;
    logic [11:0]      col;
    logic [11:0]      row;
    logic [VAL_W-1:0] value;
  } pix_word_t;

  // one output word
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             replaced;
  } pix_result_t;

  typedef enum logic [1:0] {STEP_WORD, STEP_KNOWN, STEP_REG} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    pix_word_t   w;
    pix_result_t known;
    logic [2:0]  reg_index;
    int unsigned reg_value;
  } dir_step_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // col[11:0], row[23:12], sample_value[31:24]
  logic [2:0]        s_axis_tuser = '0;   // func[0], plane[2:1]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // out_value[7:0]
  logic [0:0]        m_axis_tuser;        // replaced[0]
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [SDIM_W-1:0] cfg_data = '0;

  yuv420_keyed_logo_overlay dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Overlay model state: registers, logo stores and their written marks
  // --------------------------------------------------------------------------
  logic [SDIM_W-1:0] src_w = '0;
  logic [SDIM_W-1:0] src_h = '0;
  logic [LDIM_W-1:0] logo_w = LOGO_DIM_RESET;
  logic [LDIM_W-1:0] logo_h = LOGO_DIM_RESET;
  logic [VAL_W-1:0]  key_y = '0;

  logic [VAL_W-1:0] luma_mem [LOGO_MAX_WIDTH * LOGO_MAX_HEIGHT];
  bit               luma_wr  [LOGO_MAX_WIDTH * LOGO_MAX_HEIGHT];
  logic [VAL_W-1:0] cb_mem   [CHROMA_W * CHROMA_H];
  bit               cb_wr    [CHROMA_W * CHROMA_H];
  logic [VAL_W-1:0] cr_mem   [CHROMA_W * CHROMA_H];
  bit               cr_wr    [CHROMA_W * CHROMA_H];

  pix_result_t overlay_expect [$];   // output words still owed by the DUT

  idle_mode_e idle_mode = IDLE_NONE;
  int         mismatches = 0;
  int         words_sent = 0;
  int         phase_no = 0;
  int         hold_asked = 0;        // bumped by stimulus, served by the receiver
  int         hold_taken = 0;
  int         hold_left = 0;

  // Logo position of source luma (sx, sy) with the logo centred; 1 if under it.
  // Dims are clamped first; the centring offset truncates toward zero.
  function automatic bit under_logo(input int sx, input int sy, output int lx, output int ly);
    int lw, lh, sw, sh;
    lw = (logo_w > LOGO_MAX_WIDTH) ? LOGO_MAX_WIDTH : int'(logo_w);
    lh = (logo_h > LOGO_MAX_HEIGHT) ? LOGO_MAX_HEIGHT : int'(logo_h);
    sw = (src_w > FRAME_MAX_DIM) ? FRAME_MAX_DIM : int'(src_w);
    sh = (src_h > FRAME_MAX_DIM) ? FRAME_MAX_DIM : int'(src_h);
    lx = sx - (sw - lw) / 2;
    ly = sy - (sh - lh) / 2;
    return lx >= 0 && ly >= 0 && lx < lw && ly < lh;
  endfunction

  // Output of one process word. blind flags a read of a store entry never loaded.
  function automatic void overlay_predict(input pix_word_t w, output pix_result_t r,
                                          output bit blind);
    int lx, ly, la, ca, k;
    logic [VAL_W-1:0] y;
    r.value = w.value;
    r.replaced = 1'b0;
    blind = 1'b0;
    if (w.plane == PLANE_Y) begin
      if (under_logo(int'(w.col), int'(w.row), lx, ly)) begin
        la = ly * LOGO_MAX_WIDTH + lx;
        if (!luma_wr[la]) blind = 1'b1;
        y = luma_mem[la];
        if (y != 8'd0 && y != key_y) begin
          r.value = y;
          r.replaced = 1'b1;
        end
      end
    end else if (w.plane == PLANE_CB || w.plane == PLANE_CR) begin
      // four luma positions in raster order; the last opaque one wins
      for (k = 0; k < 4; k++) begin
        if (under_logo(2 * int'(w.col) + (k & 1), 2 * int'(w.row) + (k >> 1), lx, ly)) begin
          la = ly * LOGO_MAX_WIDTH + lx;
          ca = (ly / 2) * CHROMA_W + lx / 2;
          if (!luma_wr[la]) blind = 1'b1;
          y = luma_mem[la];
          if (y != 8'd0 && y != key_y) begin
            if (w.plane == PLANE_CB) begin
              if (!cb_wr[ca]) blind = 1'b1;
              r.value = cb_mem[ca];
            end else begin
              if (!cr_wr[ca]) blind = 1'b1;
              r.value = cr_mem[ca];
            end
            r.replaced = 1'b1;
          end
        end
      end
    end
  endfunction

  function automatic pix_word_t word_of(input logic func, input logic [1:0] plane,
                                        input int col, input int row, input int value);
    pix_word_t w;
    w.func = func;
    w.plane = plane;
    w.col = col[11:0];
    w.row = row[11:0];
    w.value = value[7:0];
    return w;
  endfunction

  function automatic int clip_coord(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // a quarter zero, a quarter key colour, the rest anything
  function automatic int logo_luma_value();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return int'(key_y);
      default: return int'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Tasks start and end just after a falling edge.
  // --------------------------------------------------------------------------
  task automatic put_word(input pix_word_t w, input bit known, input pix_result_t known_res);
    pix_result_t r;
    bit blind;
    int gap_pct, a;
    gap_pct = (idle_mode == IDLE_SENDER) ? 75 : (idle_mode == IDLE_BOTH) ? 31 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w.value, w.row, w.col};
    s_axis_tuser <= {w.plane, w.func};
    do @(posedge clk); while (!s_axis_tready);
    if (w.func == FUNC_LOAD) begin
      // out-of-range loads and plane 3 leave the stores alone
      case (w.plane)
        PLANE_Y: begin
          if (w.col < LOGO_MAX_WIDTH && w.row < LOGO_MAX_HEIGHT) begin
            a = int'(w.row) * LOGO_MAX_WIDTH + int'(w.col);
            luma_mem[a] = w.value;
            luma_wr[a] = 1'b1;
          end
        end
        PLANE_CB: begin
          if (w.col < CHROMA_W && w.row < CHROMA_H) begin
            a = int'(w.row) * CHROMA_W + int'(w.col);
            cb_mem[a] = w.value;
            cb_wr[a] = 1'b1;
          end
        end
        PLANE_CR: begin
          if (w.col < CHROMA_W && w.row < CHROMA_H) begin
            a = int'(w.row) * CHROMA_W + int'(w.col);
            cr_mem[a] = w.value;
            cr_wr[a] = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      overlay_predict(w, r, blind);
      overlay_expect.push_back(known ? known_res : r);
    end
    words_sent++;
    @(negedge clk);
  endtask

  // Input goes quiet until every owed word is out, then the pipe gets time to
  // empty of load words, which return nothing.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (overlay_expect.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 3) @(negedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no low step; the caller
  // drops it after the last one.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[SDIM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_WIDTH:  src_w = value[12:0];
      REG_SOURCE_HEIGHT: src_h = value[12:0];
      REG_LOGO_WIDTH:    logo_w = value[9:0];
      REG_LOGO_HEIGHT:   logo_h = value[9:0];
      REG_KEY_LUMA:      key_y = value[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // One geometry: program it, load a patch of logo, then aim words at that patch.
  task automatic run_phase(input int unsigned sw, input int unsigned sh, input int unsigned lw,
                           input int unsigned lh, input int unsigned key, input int proc_words);
    int lw_c, lh_c, pw, ph, px0, py0, offx, offy, lx, ly, sx, sy, n, pick, tries;
    logic [1:0] plane;
    pix_word_t w;
    pix_result_t r;
    bit blind;
    settle();
    idle_mode <= idle_mode_e'(phase_no % 4);
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_LOGO_WIDTH, lw);
    write_reg(REG_LOGO_HEIGHT, lh);
    write_reg(REG_KEY_LUMA, key);
    cfg_valid <= 1'b0;

    lw_c = (logo_w > LOGO_MAX_WIDTH) ? LOGO_MAX_WIDTH : int'(logo_w);
    lh_c = (logo_h > LOGO_MAX_HEIGHT) ? LOGO_MAX_HEIGHT : int'(logo_h);
    // source position = logo position + offset
    void'(under_logo(0, 0, offx, offy));
    offx = -offx;
    offy = -offy;

    // patch: whole logo when narrow, else a random block of up to 8 x 8
    pw = (lw_c < 8) ? lw_c : int'($urandom_range(2, 8));
    ph = (lh_c < 8) ? lh_c : int'($urandom_range(2, 8));
    if (pw == 0 || ph == 0) begin
      pw = 0;
      ph = 0;
    end
    px0 = int'($urandom_range(0, lw_c - pw));
    py0 = int'($urandom_range(0, lh_c - ph));
    if (pw > 0) begin
      for (ly = py0; ly < py0 + ph; ly++)
        for (lx = px0; lx < px0 + pw; lx++)
          put_word(word_of(FUNC_LOAD, PLANE_Y, lx, ly, logo_luma_value()), 1'b0, '0);
      for (ly = py0 / 2; ly <= (py0 + ph - 1) / 2; ly++)
        for (lx = px0 / 2; lx <= (px0 + pw - 1) / 2; lx++) begin
          put_word(word_of(FUNC_LOAD, PLANE_CB, lx, ly, $urandom_range(0, 255)), 1'b0, '0);
          put_word(word_of(FUNC_LOAD, PLANE_CR, lx, ly, $urandom_range(0, 255)), 1'b0, '0);
        end
    end

    for (n = 0; n < proc_words; n++) begin
      if (n == proc_words / 2) begin
        // receiver goes quiet for a long while; input keeps coming until it backs up
        if (phase_no == 4) hold_asked <= hold_asked + 1;
        // sender waits for the output side to catch up completely
        if (phase_no == 5) settle();
      end
      pick = int'($urandom_range(0, 99));
      tries = 0;
      if (pick < 15 || pw == 0) begin
        // noise: any fields at all, but never a blind read
        do begin
          w = word_of($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 255));
          overlay_predict(w, r, blind);
          tries++;
        end while (w.func == FUNC_PROC && blind && tries < 100);
      end else if (pick < 30) begin
        // reload a patch sample, keeps the key test moving
        lx = px0 + int'($urandom_range(0, pw - 1));
        ly = py0 + int'($urandom_range(0, ph - 1));
        plane = $urandom_range(0, 2);
        if (plane == PLANE_Y)
          w = word_of(FUNC_LOAD, plane, lx, ly, logo_luma_value());
        else
          w = word_of(FUNC_LOAD, plane, lx / 2, ly / 2, $urandom_range(0, 255));
        blind = 1'b0;
      end else begin
        // source sample over or just beside the patch
        do begin
          lx = px0 + int'($urandom_range(0, pw - 1)) + int'($urandom_range(0, 4)) - 2;
          ly = py0 + int'($urandom_range(0, ph - 1)) + int'($urandom_range(0, 4)) - 2;
          sx = lx + offx;
          sy = ly + offy;
          plane = $urandom_range(0, 2);
          if (plane != PLANE_Y) begin
            sx = (sx < 0) ? 0 : sx / 2;
            sy = (sy < 0) ? 0 : sy / 2;
          end
          w = word_of(FUNC_PROC, plane, clip_coord(sx), clip_coord(sy), $urandom_range(0, 255));
          overlay_predict(w, r, blind);
          tries++;
        end while (blind && tries < 100);
      end
      // plane 3 reads nothing, so it is the safe fallback
      if (w.func == FUNC_PROC && blind) w.plane = PLANE_NONE;
      put_word(w, 1'b0, '0);
    end
    phase_no++;
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready pattern and the checker
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_taken + 1;
      hold_left <= RX_HOLD_WORDS - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >=
                       ((idle_mode == IDLE_RECEIVER) ? 75 : (idle_mode == IDLE_BOTH) ? 31 : 0);
    end
  end

  always @(posedge clk) begin
    pix_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (overlay_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: output word with none owed: value %02h replaced %0d",
                   $realtime, m_axis_tdata, m_axis_tuser[0]);
      end else begin
        want = overlay_expect.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser[0] !== want.replaced) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected value %02h replaced %0d, got value %02h replaced %0d",
                     $realtime, want.value, want.replaced, m_axis_tdata, m_axis_tuser[0]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------
  function automatic dir_step_t step_word(input logic func, input logic [1:0] plane,
                                          input int col, input int row, input int value);
    dir_step_t s;
    s.kind = STEP_WORD;
    s.w = word_of(func, plane, col, row, value);
    s.known = '0;
    s.reg_index = '0;
    s.reg_value = 0;
    return s;
  endfunction

  function automatic dir_step_t step_known(input logic func, input logic [1:0] plane,
                                           input int col, input int row, input int value,
                                           input int want_value, input logic want_rep);
    dir_step_t s;
    s = step_word(func, plane, col, row, value);
    s.kind = STEP_KNOWN;
    s.known.value = want_value[7:0];
    s.known.replaced = want_rep;
    return s;
  endfunction

  function automatic dir_step_t step_reg(input logic [2:0] idx, input int unsigned value);
    dir_step_t s;
    s = step_word(FUNC_LOAD, PLANE_NONE, 0, 0, 0);
    s.kind = STEP_REG;
    s.reg_index = idx;
    s.reg_value = value;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    dir_step_t directed [$];
    int i;

    // Reset geometry: source 0 x 0, logo 360 x 360, so the offset is -180 and
    // source (0,0) sits over logo (180,180). Only a 2x2 logo block gets loaded.
    directed = '{
      // far outside the logo, plane 3, stray loads that must be dropped
      step_known(FUNC_PROC, PLANE_Y,    4095, 4095, 8'hFF, 8'hFF, 1'b0),
      step_known(FUNC_PROC, PLANE_CB,   4095, 4095, 8'h00, 8'h00, 1'b0),
      step_known(FUNC_PROC, PLANE_CR,   2048, 2048, 8'h5A, 8'h5A, 1'b0),
      step_known(FUNC_PROC, PLANE_NONE, 0,    0,    8'hA5, 8'hA5, 1'b0),
      step_word (FUNC_LOAD, PLANE_NONE, 0,    0,    8'h77),
      step_word (FUNC_LOAD, PLANE_Y,    512,  0,    8'h11),
      step_word (FUNC_LOAD, PLANE_Y,    0,    4095, 8'h22),
      step_word (FUNC_LOAD, PLANE_CB,   256,  0,    8'h33),
      step_word (FUNC_LOAD, PLANE_CR,   0,    256,  8'h44),
      // 2x2 luma block: max, zero (always clear), min nonzero, mid
      step_word (FUNC_LOAD, PLANE_Y,    180,  180,  8'hFF),
      step_word (FUNC_LOAD, PLANE_Y,    181,  180,  8'h00),
      step_word (FUNC_LOAD, PLANE_Y,    180,  181,  8'h01),
      step_word (FUNC_LOAD, PLANE_Y,    181,  181,  8'h80),
      step_word (FUNC_LOAD, PLANE_CB,   90,   90,   8'h00),
      step_word (FUNC_LOAD, PLANE_CR,   90,   90,   8'hFF),
      step_known(FUNC_PROC, PLANE_Y,    0,    0,    8'h33, 8'hFF, 1'b1),
      step_known(FUNC_PROC, PLANE_Y,    1,    0,    8'h44, 8'h44, 1'b0),
      step_known(FUNC_PROC, PLANE_Y,    0,    1,    8'h55, 8'h01, 1'b1),
      step_known(FUNC_PROC, PLANE_Y,    1,    1,    8'h00, 8'h80, 1'b1),
      step_known(FUNC_PROC, PLANE_CB,   0,    0,    8'h12, 8'h00, 1'b1),
      step_known(FUNC_PROC, PLANE_CR,   0,    0,    8'h34, 8'hFF, 1'b1),
      // just right of the logo edge
      step_known(FUNC_PROC, PLANE_Y,    180,  0,    8'hC3, 8'hC3, 1'b0),
      // key hits the bottom-right pixel; chroma falls back to an earlier one
      step_reg  (REG_KEY_LUMA, 8'h80),
      step_known(FUNC_PROC, PLANE_Y,    1,    1,    8'h9C, 8'h9C, 1'b0),
      step_word (FUNC_PROC, PLANE_CB,   0,    0,    8'h21),
      // key at full scale
      step_reg  (REG_KEY_LUMA, 8'hFF),
      step_known(FUNC_PROC, PLANE_Y,    0,    0,    8'h66, 8'h66, 1'b0)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < directed.size(); i++) begin
      case (directed[i].kind)
        STEP_REG: begin
          settle();
          write_reg(directed[i].reg_index, directed[i].reg_value);
          cfg_valid <= 1'b0;
        end
        STEP_KNOWN: put_word(directed[i].w, 1'b1, directed[i].known);
        default:    put_word(directed[i].w, 1'b0, '0);
      endcase
    end

    // fixed phases: one idle mode each, in turn
    run_phase(64, 48, 16, 8, $urandom_range(0, 255), 60);
    run_phase(8191, 8191, 1023, 1023, 8'hFF, 60);       // everything clamps
    run_phase(0, 0, 0, 0, 0, 40);                       // empty logo
    run_phase(20, 12, 40, 30, $urandom_range(0, 255), 60); // logo bigger than frame
    run_phase(4096, 4096, 512, 512, $urandom_range(0, 255), 80);
    run_phase(33, 17, 7, 5, 0, 60);                     // odd sizes
    // random geometries, now and then the full register range
    while (words_sent < 1000) begin
      run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 96),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 96),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24),
                $urandom_range(0, 255), 80);
    end

    settle();
    if (mismatches == 0 && overlay_expect.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lko_pkg.sv
hw/rtl/lko_ram.sv
hw/rtl/lko_geom.sv
hw/rtl/lko_lookup.sv
hw/rtl/yuv420_keyed_logo_overlay.sv
bench/tb.sv
